FILE: hdl/ec_point_arith_unit_macros.svh
// assertion macros for the checker file of the point arithmetic unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef EC_POINT_ARITH_UNIT_MACROS_SVH
`define EC_POINT_ARITH_UNIT_MACROS_SVH

// checked only while reset is released
`define ECPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ecpa port check failed");

// checked at every edge, reset included
`define ECPA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ecpa reset check failed");

`endif

FILE: hdl/ecpa_pkg.sv
// types, codes and microcode program of the elliptic curve point arithmetic unit
// no dependencies; used by ec_point_arith_unit and its checker
package ecpa_pkg;

    localparam int FIELD_BITS   = 31;
    localparam int SCALAR_BITS  = 32;
    localparam int PC_BITS      = 6;
    localparam int CFG_IDX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_P = 1'd1;

    localparam logic [FIELD_BITS-1:0] CURVE_A_RESET = FIELD_BITS'(1);
    localparam logic [FIELD_BITS-1:0] PRIME_P_RESET = FIELD_BITS'(23);

    // request codes
    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;

    typedef logic [FIELD_BITS-1:0] t_fe;

    typedef struct packed {
        logic [1:0]             req_type;
        t_fe                    p_x;
        t_fe                    p_y;
        logic                   p_inf;
        t_fe                    q_x;
        t_fe                    q_y;
        logic                   q_inf;
        logic [SCALAR_BITS-1:0] scalar_k;
    } t_req;

    typedef struct packed {
        t_fe  r_x;
        t_fe  r_y;
        logic r_inf;
    } t_res;

    typedef struct packed {
        logic inf;
        t_fe  y;
        t_fe  x;
    } t_pt;

    // micro-operations
    typedef enum logic [4:0] {
        UOP_JMP,
        UOP_CALL,
        UOP_RET,
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_INV,
        UOP_U_FROM_V,
        UOP_U_FROM_C,
        UOP_U_FROM_B,
        UOP_V_FROM_B,
        UOP_B_FROM_U,
        UOP_C_FROM_U,
        UOP_U_INF,
        UOP_C_INF,
        UOP_KSHIFT,
        UOP_DONE
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_BAD,
        COND_OP_MUL,
        COND_OP_ADD,
        COND_V_INF,
        COND_U_INF,
        COND_NEG,
        COND_EQ,
        COND_K_ZERO,
        COND_K_EVEN
    } t_cond;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_UX,
        SRC_UY,
        SRC_VX,
        SRC_VY,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_A,
        SRC_RAW_A,
        SRC_RAW_PX,
        SRC_RAW_PY,
        SRC_RAW_QX,
        SRC_RAW_QY
    } t_src;

    typedef enum logic [2:0] {
        DST_UX,
        DST_UY,
        DST_VX,
        DST_VY,
        DST_T0,
        DST_T1,
        DST_T2,
        DST_A
    } t_dst;

    typedef struct packed {
        t_uop               op;
        t_cond              cond;
        t_dst               dst;
        t_src               sa;
        t_src               sb;
        logic [PC_BITS-1:0] tgt;
    } t_uword;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_WAIT
    } t_seq_state;

    typedef enum logic [2:0] {
        INV_IDLE,
        INV_CHECK,
        INV_ALIGN,
        INV_DIV,
        INV_FIX
    } t_inv_state;

    // program labels
    localparam logic [PC_BITS-1:0] L_DOADD   = 6'd10;
    localparam logic [PC_BITS-1:0] L_SMUL    = 6'd12;
    localparam logic [PC_BITS-1:0] L_LOOP    = 6'd14;
    localparam logic [PC_BITS-1:0] L_DBLB    = 6'd20;
    localparam logic [PC_BITS-1:0] L_FINC    = 6'd26;
    localparam logic [PC_BITS-1:0] L_FIN_INF = 6'd28;
    localparam logic [PC_BITS-1:0] L_FIN     = 6'd29;
    localparam logic [PC_BITS-1:0] L_PADD    = 6'd30;
    localparam logic [PC_BITS-1:0] L_DBL     = 6'd37;
    localparam logic [PC_BITS-1:0] L_COM     = 6'd42;
    localparam logic [PC_BITS-1:0] L_RETL    = 6'd51;
    localparam logic [PC_BITS-1:0] L_CPV     = 6'd52;
    localparam logic [PC_BITS-1:0] L_SETI    = 6'd54;
    localparam logic [PC_BITS-1:0] L_NONE    = 6'd0;

    function automatic t_uword uw(t_uop op, t_cond cond, t_dst dst, t_src sa, t_src sb,
                                  logic [PC_BITS-1:0] tgt);
        t_uword w;
        w.op   = op;
        w.cond = cond;
        w.dst  = dst;
        w.sa   = sa;
        w.sb   = sb;
        w.tgt  = tgt;
        return w;
    endfunction

    // control store: main program, then the point add subroutine (U = U + V)
    function automatic t_uword ecpa_ucode(logic [PC_BITS-1:0] pc);
        t_uword w;
        case (pc)
            // reject bad modulus or unused request code
            6'd0:  w = uw(UOP_JMP, COND_BAD, DST_T0, SRC_ZERO, SRC_ZERO, L_FIN_INF);
            // reduce curve a and operands below the modulus
            6'd1:  w = uw(UOP_MUL, COND_ALWAYS, DST_A,  SRC_ONE, SRC_RAW_A,  L_NONE);
            6'd2:  w = uw(UOP_MUL, COND_ALWAYS, DST_UX, SRC_ONE, SRC_RAW_PX, L_NONE);
            6'd3:  w = uw(UOP_MUL, COND_ALWAYS, DST_UY, SRC_ONE, SRC_RAW_PY, L_NONE);
            6'd4:  w = uw(UOP_MUL, COND_ALWAYS, DST_VX, SRC_ONE, SRC_RAW_QX, L_NONE);
            6'd5:  w = uw(UOP_MUL, COND_ALWAYS, DST_VY, SRC_ONE, SRC_RAW_QY, L_NONE);
            6'd6:  w = uw(UOP_JMP, COND_OP_MUL, DST_T0, SRC_ZERO, SRC_ZERO, L_SMUL);
            6'd7:  w = uw(UOP_JMP, COND_OP_ADD, DST_T0, SRC_ZERO, SRC_ZERO, L_DOADD);
            6'd8:  w = uw(UOP_JMP, COND_V_INF,  DST_T0, SRC_ZERO, SRC_ZERO, L_DOADD);
            6'd9:  w = uw(UOP_SUB, COND_ALWAYS, DST_VY, SRC_ZERO, SRC_VY,   L_NONE);
            6'd10: w = uw(UOP_CALL, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_PADD);
            6'd11: w = uw(UOP_JMP, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_FIN);
            // scalar multiply, right to left
            6'd12: w = uw(UOP_B_FROM_U, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd13: w = uw(UOP_C_INF,    COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd14: w = uw(UOP_JMP, COND_K_ZERO, DST_T0, SRC_ZERO, SRC_ZERO, L_FINC);
            6'd15: w = uw(UOP_JMP, COND_K_EVEN, DST_T0, SRC_ZERO, SRC_ZERO, L_DBLB);
            6'd16: w = uw(UOP_U_FROM_C, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd17: w = uw(UOP_V_FROM_B, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd18: w = uw(UOP_CALL, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_PADD);
            6'd19: w = uw(UOP_C_FROM_U, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd20: w = uw(UOP_U_FROM_B, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd21: w = uw(UOP_V_FROM_B, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd22: w = uw(UOP_CALL, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_PADD);
            6'd23: w = uw(UOP_B_FROM_U, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd24: w = uw(UOP_KSHIFT,   COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd25: w = uw(UOP_JMP, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_LOOP);
            6'd26: w = uw(UOP_U_FROM_C, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd27: w = uw(UOP_JMP, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_FIN);
            6'd28: w = uw(UOP_U_INF, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd29: w = uw(UOP_DONE,  COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            // point add subroutine: special cases first
            6'd30: w = uw(UOP_JMP, COND_U_INF, DST_T0, SRC_ZERO, SRC_ZERO, L_CPV);
            6'd31: w = uw(UOP_JMP, COND_V_INF, DST_T0, SRC_ZERO, SRC_ZERO, L_RETL);
            6'd32: w = uw(UOP_JMP, COND_NEG,   DST_T0, SRC_ZERO, SRC_ZERO, L_SETI);
            6'd33: w = uw(UOP_JMP, COND_EQ,    DST_T0, SRC_ZERO, SRC_ZERO, L_DBL);
            // chord slope terms
            6'd34: w = uw(UOP_SUB, COND_ALWAYS, DST_T0, SRC_VY, SRC_UY, L_NONE);
            6'd35: w = uw(UOP_SUB, COND_ALWAYS, DST_T1, SRC_VX, SRC_UX, L_NONE);
            6'd36: w = uw(UOP_JMP, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_COM);
            // tangent slope terms
            6'd37: w = uw(UOP_MUL, COND_ALWAYS, DST_T1, SRC_UX, SRC_UX, L_NONE);
            6'd38: w = uw(UOP_ADD, COND_ALWAYS, DST_T0, SRC_T1, SRC_T1, L_NONE);
            6'd39: w = uw(UOP_ADD, COND_ALWAYS, DST_T0, SRC_T0, SRC_T1, L_NONE);
            6'd40: w = uw(UOP_ADD, COND_ALWAYS, DST_T0, SRC_T0, SRC_A,  L_NONE);
            6'd41: w = uw(UOP_ADD, COND_ALWAYS, DST_T1, SRC_UY, SRC_UY, L_NONE);
            // slope and new point
            6'd42: w = uw(UOP_INV, COND_ALWAYS, DST_T1, SRC_T1, SRC_ZERO, L_NONE);
            6'd43: w = uw(UOP_MUL, COND_ALWAYS, DST_T0, SRC_T0, SRC_T1, L_NONE);
            6'd44: w = uw(UOP_MUL, COND_ALWAYS, DST_T1, SRC_T0, SRC_T0, L_NONE);
            6'd45: w = uw(UOP_SUB, COND_ALWAYS, DST_T1, SRC_T1, SRC_UX, L_NONE);
            6'd46: w = uw(UOP_SUB, COND_ALWAYS, DST_T1, SRC_T1, SRC_VX, L_NONE);
            6'd47: w = uw(UOP_SUB, COND_ALWAYS, DST_T2, SRC_UX, SRC_T1, L_NONE);
            6'd48: w = uw(UOP_MUL, COND_ALWAYS, DST_T2, SRC_T0, SRC_T2, L_NONE);
            6'd49: w = uw(UOP_SUB, COND_ALWAYS, DST_UY, SRC_T2, SRC_UY, L_NONE);
            6'd50: w = uw(UOP_ADD, COND_ALWAYS, DST_UX, SRC_T1, SRC_ZERO, L_NONE);
            6'd51: w = uw(UOP_RET, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd52: w = uw(UOP_U_FROM_V, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd53: w = uw(UOP_RET, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd54: w = uw(UOP_U_INF, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            6'd55: w = uw(UOP_RET, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
            default: w = uw(UOP_DONE, COND_ALWAYS, DST_T0, SRC_ZERO, SRC_ZERO, L_NONE);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/ec_point_arith_unit.sv
// Affine point add, subtract and scalar multiply on y^2 = x^3 + ax + b over GF(p).
// Every field operation of a request is issued by the microcoded sequencer to one
// shared datapath, where a modular multiply runs bit serially over the bits of its
// second operand and the modular inverse is an extended Euclid loop that finds each
// quotient bit by shift and subtract. Operand reduction costs five multiply passes
// per request that is not rejected as bad. One request is in work at a time; a
// finished result waits in the output register while the next request is taken.
// Depends on ecpa_pkg.
module ec_point_arith_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ecpa_pkg::t_req                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ecpa_pkg::t_res                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [ecpa_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ecpa_pkg::FIELD_BITS-1:0]     i_cfg_data
);
    import ecpa_pkg::*;

    localparam int SW     = FIELD_BITS + 3;
    localparam int J_BITS = $clog2(FIELD_BITS);
    localparam int C_BITS = $clog2(FIELD_BITS);

    // configuration
    t_fe r_curve_a, r_prime_p;

    // sequencer
    t_seq_state         r_state, n_state;
    logic [PC_BITS-1:0] r_pc, n_pc, r_ret, n_ret;
    t_uword             w_uw;
    logic               w_cond;
    logic               w_in_acc;

    // datapath registers
    t_req                   r_req, n_req;
    t_pt                    r_u, n_u, r_v, n_v, r_c, n_c, r_b, n_b;
    t_fe                    r_t0, n_t0, r_t1, n_t1, r_t2, n_t2, r_a, n_a;
    logic [SCALAR_BITS-1:0] r_k, n_k;
    t_fe                    w_opa, w_opb, w_wr_val;
    logic                   w_wr_en;
    logic [FIELD_BITS:0]    w_sum, w_diff;
    t_fe                    w_add_res, w_sub_res;

    // output register
    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;

    // bit-serial modular multiplier
    t_fe                 r_mul_acc, n_mul_acc, r_mul_u, n_mul_u, r_mul_v, n_mul_v;
    logic [C_BITS-1:0]   r_mul_cnt, n_mul_cnt;
    logic [FIELD_BITS+1:0] w_mul_t, w_mul_m1, w_mul_m2, w_mul_red;
    logic                w_mul_done;

    // extended euclid inverse
    t_inv_state          r_inv_state, n_inv_state;
    t_fe                 r_r0, n_r0, r_r1, n_r1, r_d, n_d;
    logic signed [SW-1:0] r_s0, n_s0, r_s1, n_s1, r_s1sh, n_s1sh;
    logic [J_BITS-1:0]   r_j, n_j;
    logic                w_inv_start, w_inv_done, w_div_take;
    t_fe                 w_rem, w_inv_res;
    logic signed [SW-1:0] w_snew, w_m_s, w_s_fix;

    assign w_uw       = ecpa_ucode(r_pc);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == SEQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // operand select
    always_comb begin
        case (w_uw.sa)
            SRC_ZERO:   w_opa = '0;
            SRC_ONE:    w_opa = FIELD_BITS'(1);
            SRC_UX:     w_opa = r_u.x;
            SRC_UY:     w_opa = r_u.y;
            SRC_VX:     w_opa = r_v.x;
            SRC_VY:     w_opa = r_v.y;
            SRC_T0:     w_opa = r_t0;
            SRC_T1:     w_opa = r_t1;
            SRC_T2:     w_opa = r_t2;
            SRC_A:      w_opa = r_a;
            SRC_RAW_A:  w_opa = r_curve_a;
            SRC_RAW_PX: w_opa = r_req.p_x;
            SRC_RAW_PY: w_opa = r_req.p_y;
            SRC_RAW_QX: w_opa = r_req.q_x;
            SRC_RAW_QY: w_opa = r_req.q_y;
            default:    w_opa = '0;
        endcase
        case (w_uw.sb)
            SRC_ZERO:   w_opb = '0;
            SRC_ONE:    w_opb = FIELD_BITS'(1);
            SRC_UX:     w_opb = r_u.x;
            SRC_UY:     w_opb = r_u.y;
            SRC_VX:     w_opb = r_v.x;
            SRC_VY:     w_opb = r_v.y;
            SRC_T0:     w_opb = r_t0;
            SRC_T1:     w_opb = r_t1;
            SRC_T2:     w_opb = r_t2;
            SRC_A:      w_opb = r_a;
            SRC_RAW_A:  w_opb = r_curve_a;
            SRC_RAW_PX: w_opb = r_req.p_x;
            SRC_RAW_PY: w_opb = r_req.p_y;
            SRC_RAW_QX: w_opb = r_req.q_x;
            SRC_RAW_QY: w_opb = r_req.q_y;
            default:    w_opb = '0;
        endcase
    end

    // modular add and subtract on reduced operands
    always_comb begin
        w_sum = {1'b0, w_opa} + {1'b0, w_opb};
        if (w_sum >= {1'b0, r_prime_p}) begin
            w_sum = w_sum - {1'b0, r_prime_p};
        end
        w_add_res = w_sum[FIELD_BITS-1:0];
        w_diff = {1'b0, w_opa} - {1'b0, w_opb};
        if (w_opa < w_opb) begin
            w_diff = w_diff + {1'b0, r_prime_p};
        end
        w_sub_res = w_diff[FIELD_BITS-1:0];
    end

    // jump condition
    always_comb begin
        logic [FIELD_BITS:0] ysum;
        ysum = {1'b0, r_u.y} + {1'b0, r_v.y};
        case (w_uw.cond)
            COND_ALWAYS: w_cond = 1'b1;
            COND_BAD:    w_cond = (r_prime_p < FIELD_BITS'(2)) ||
                                  !(r_req.req_type inside {REQ_ADD, REQ_SUB, REQ_MUL});
            COND_OP_MUL: w_cond = (r_req.req_type == REQ_MUL);
            COND_OP_ADD: w_cond = (r_req.req_type == REQ_ADD);
            COND_V_INF:  w_cond = r_v.inf;
            COND_U_INF:  w_cond = r_u.inf;
            COND_NEG:    w_cond = (r_u.x == r_v.x) &&
                                  ((ysum == '0) || (ysum == {1'b0, r_prime_p}));
            COND_EQ:     w_cond = (r_u.x == r_v.x) && (r_u.y == r_v.y);
            COND_K_ZERO: w_cond = (r_k == '0);
            COND_K_EVEN: w_cond = !r_k[0];
            default:     w_cond = 1'b0;
        endcase
    end

    // multiplier step: acc = 2*acc + bit*u, reduced from below 3p
    always_comb begin
        w_mul_m1  = {2'b00, r_prime_p};
        w_mul_m2  = {1'b0, r_prime_p, 1'b0};
        w_mul_t   = {1'b0, r_mul_acc, 1'b0} +
                    {2'b00, (r_mul_v[FIELD_BITS-1] ? r_mul_u : t_fe'(0))};
        if (w_mul_t >= w_mul_m2) begin
            w_mul_red = w_mul_t - w_mul_m2;
        end else if (w_mul_t >= w_mul_m1) begin
            w_mul_red = w_mul_t - w_mul_m1;
        end else begin
            w_mul_red = w_mul_t;
        end
    end

    assign w_mul_done = (r_state == SEQ_WAIT) && (w_uw.op == UOP_MUL) && (r_mul_cnt == '0);

    // inverse: long division remainder and bezout update
    always_comb begin
        w_div_take = (r_r0 >= r_d);
        w_rem      = w_div_take ? (r_r0 - r_d) : r_r0;
        w_snew     = w_div_take ? (r_s0 - r_s1sh) : r_s0;
        w_m_s      = SW'(signed'({1'b0, r_prime_p}));
        w_s_fix    = r_s0;
        if (w_s_fix < 0) begin
            w_s_fix = w_s_fix + w_m_s;
        end
        if (w_s_fix >= w_m_s) begin
            w_s_fix = w_s_fix - w_m_s;
        end
        w_inv_res = (r_r0 != FIELD_BITS'(1)) ? (r_prime_p - FIELD_BITS'(1))
                                              : w_s_fix[FIELD_BITS-1:0];
    end

    assign w_inv_start = (r_state == SEQ_RUN) && (w_uw.op == UOP_INV);
    assign w_inv_done  = (r_inv_state == INV_FIX);

    // inverse next state
    always_comb begin
        n_inv_state = r_inv_state;
        case (r_inv_state)
            INV_IDLE:  if (w_inv_start) n_inv_state = INV_CHECK;
            INV_CHECK: n_inv_state = (r_r1 == '0) ? INV_FIX : INV_ALIGN;
            INV_ALIGN: if ({r_d, 1'b0} > {1'b0, r_r0}) n_inv_state = INV_DIV;
            INV_DIV:   if (r_j == '0) n_inv_state = INV_CHECK;
            INV_FIX:   n_inv_state = INV_IDLE;
            default:   n_inv_state = INV_IDLE;
        endcase
    end

    // inverse datapath
    always_comb begin
        n_r0   = r_r0;
        n_r1   = r_r1;
        n_d    = r_d;
        n_s0   = r_s0;
        n_s1   = r_s1;
        n_s1sh = r_s1sh;
        n_j    = r_j;
        case (r_inv_state)
            INV_IDLE: begin
                if (w_inv_start) begin
                    n_r0 = w_opa;
                    n_r1 = r_prime_p;
                    n_s0 = SW'(1);
                    n_s1 = '0;
                end
            end
            INV_CHECK: begin
                n_d    = r_r1;
                n_s1sh = r_s1;
                n_j    = '0;
            end
            INV_ALIGN: begin
                if ({r_d, 1'b0} <= {1'b0, r_r0}) begin
                    n_d    = {r_d[FIELD_BITS-2:0], 1'b0};
                    n_s1sh = r_s1sh <<< 1;
                    n_j    = r_j + J_BITS'(1);
                end
            end
            INV_DIV: begin
                if (r_j == '0) begin
                    n_r0 = r_r1;
                    n_r1 = w_rem;
                    n_s0 = r_s1;
                    n_s1 = w_snew;
                end else begin
                    n_r0   = w_rem;
                    n_s0   = w_snew;
                    n_d    = r_d >> 1;
                    n_s1sh = r_s1sh >>> 1;
                    n_j    = r_j - J_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: if (w_in_acc) n_state = SEQ_RUN;
            SEQ_RUN: begin
                case (w_uw.op)
                    UOP_MUL, UOP_INV: n_state = SEQ_WAIT;
                    UOP_DONE: if (!r_out_valid || i_out_ready) n_state = SEQ_IDLE;
                    default:  n_state = SEQ_RUN;
                endcase
            end
            SEQ_WAIT: if (w_mul_done || w_inv_done) n_state = SEQ_RUN;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        n_pc        = r_pc;
        n_ret       = r_ret;
        n_req       = r_req;
        n_u         = r_u;
        n_v         = r_v;
        n_c         = r_c;
        n_b         = r_b;
        n_k         = r_k;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_a         = r_a;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_mul_acc   = r_mul_acc;
        n_mul_u     = r_mul_u;
        n_mul_v     = r_mul_v;
        n_mul_cnt   = r_mul_cnt;
        w_wr_en     = 1'b0;
        w_wr_val    = w_add_res;
        case (r_state)
            SEQ_IDLE: begin
                if (w_in_acc) begin
                    n_req   = i_in_data;
                    n_u.inf = i_in_data.p_inf;
                    n_v.inf = i_in_data.q_inf;
                    n_k     = i_in_data.scalar_k;
                    n_pc    = '0;
                end
            end
            SEQ_RUN: begin
                n_pc = r_pc + PC_BITS'(1);
                case (w_uw.op)
                    UOP_JMP:  if (w_cond) n_pc = w_uw.tgt;
                    UOP_CALL: begin
                        n_ret = r_pc + PC_BITS'(1);
                        n_pc  = w_uw.tgt;
                    end
                    UOP_RET:  n_pc = r_ret;
                    UOP_ADD: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_add_res;
                    end
                    UOP_SUB: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_sub_res;
                    end
                    UOP_MUL: begin
                        n_pc      = r_pc;
                        n_mul_acc = '0;
                        n_mul_u   = w_opa;
                        n_mul_v   = w_opb;
                        n_mul_cnt = C_BITS'(FIELD_BITS - 1);
                    end
                    UOP_INV:      n_pc = r_pc;
                    UOP_U_FROM_V: n_u = r_v;
                    UOP_U_FROM_C: n_u = r_c;
                    UOP_U_FROM_B: n_u = r_b;
                    UOP_V_FROM_B: n_v = r_b;
                    UOP_B_FROM_U: n_b = r_u;
                    UOP_C_FROM_U: n_c = r_u;
                    UOP_U_INF:    n_u.inf = 1'b1;
                    UOP_C_INF:    n_c.inf = 1'b1;
                    UOP_KSHIFT:   n_k = r_k >> 1;
                    UOP_DONE: begin
                        n_pc = r_pc;
                        if (!r_out_valid || i_out_ready) begin
                            n_out_valid = 1'b1;
                            n_out.r_inf = r_u.inf;
                            n_out.r_x   = r_u.inf ? '0 : r_u.x;
                            n_out.r_y   = r_u.inf ? '0 : r_u.y;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            SEQ_WAIT: begin
                if (w_uw.op == UOP_MUL) begin
                    n_mul_acc = w_mul_red[FIELD_BITS-1:0];
                    n_mul_v   = {r_mul_v[FIELD_BITS-2:0], 1'b0};
                    n_mul_cnt = r_mul_cnt - C_BITS'(1);
                end
                if (w_mul_done) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = w_mul_red[FIELD_BITS-1:0];
                    n_pc     = r_pc + PC_BITS'(1);
                end else if (w_inv_done) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = w_inv_res;
                    n_pc     = r_pc + PC_BITS'(1);
                end
            end
            default: begin
            end
        endcase
        // destination write
        if (w_wr_en) begin
            case (w_uw.dst)
                DST_UX:  n_u.x = w_wr_val;
                DST_UY:  n_u.y = w_wr_val;
                DST_VX:  n_v.x = w_wr_val;
                DST_VY:  n_v.y = w_wr_val;
                DST_T0:  n_t0 = w_wr_val;
                DST_T1:  n_t1 = w_wr_val;
                DST_T2:  n_t2 = w_wr_val;
                DST_A:   n_a = w_wr_val;
                default: n_t0 = r_t0;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_inv_state <= INV_IDLE;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_ret       <= '0;
            r_curve_a   <= CURVE_A_RESET;
            r_prime_p   <= PRIME_P_RESET;
        end else begin
            r_state     <= n_state;
            r_inv_state <= n_inv_state;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_ret       <= n_ret;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CURVE_A: r_curve_a <= i_cfg_data;
                    CFG_PRIME_P: r_prime_p <= i_cfg_data;
                    default:     r_curve_a <= r_curve_a;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_u       <= n_u;
        r_v       <= n_v;
        r_c       <= n_c;
        r_b       <= n_b;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_a       <= n_a;
        r_k       <= n_k;
        r_out     <= n_out;
        r_mul_acc <= n_mul_acc;
        r_mul_u   <= n_mul_u;
        r_mul_v   <= n_mul_v;
        r_mul_cnt <= n_mul_cnt;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_d       <= n_d;
        r_s0      <= n_s0;
        r_s1      <= n_s1;
        r_s1sh    <= n_s1sh;
        r_j       <= n_j;
    end

endmodule

FILE: hdl/ecpa_checker.sv
// port-level checks for ec_point_arith_unit, bound into that module
// depends on ecpa_pkg and ec_point_arith_unit_macros.svh
`include "ec_point_arith_unit_macros.svh"

module ecpa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input ecpa_pkg::t_res                      o_out_data,
    input logic                                i_cfg_we,
    input logic [ecpa_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input logic [ecpa_pkg::FIELD_BITS-1:0]     i_cfg_data
);
    import ecpa_pkg::*;

    t_fe  r_prime;
    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // shadow copy of the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= PRIME_P_RESET;
        end else if (i_cfg_we && (i_cfg_idx == CFG_PRIME_P)) begin
            r_prime <= i_cfg_data;
        end
    end

    // result held while stalled
    `ECPA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)
    `ECPA_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_data))
    // infinity carries zero coordinates, finite points are reduced
    `ECPA_ASSERT(a_inf_zero, o_out_valid && o_out_data.r_inf |-> (o_out_data.r_x == '0) && (o_out_data.r_y == '0))
    `ECPA_ASSERT(a_reduced, o_out_valid && !o_out_data.r_inf |-> (o_out_data.r_x < r_prime) && (o_out_data.r_y < r_prime))
    // no result appears right after a request is taken
    `ECPA_ASSERT(a_no_early, w_in_acc |=> !$rose(o_out_valid))

endmodule

bind ec_point_arith_unit ecpa_checker u_ecpa_checker (.*);
